>>> rtl/core/assert_macros.svh
// assertion macros used by the rtl top of the deframer
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

>>> rtl/core/ffd_pkg.sv
// package for the flag-framed destuffer with crc-16 check
// holds constants, result struct, status codes and crc functions; no dependencies
`default_nettype none

package ffd_pkg;

    // payload counter width, saturating
    localparam int LENGTH_BITS = 10;
    // width of the reported length field
    localparam int LEN_OUT_BITS = 10;
    localparam int LEN_WIDE = (LENGTH_BITS > LEN_OUT_BITS) ? LENGTH_BITS : LEN_OUT_BITS;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_BAD_CRC = 2'd1,
        STATUS_SHORT   = 2'd2,
        STATUS_ESCAPE  = 2'd3
    } frame_status_t;

    // one result item
    typedef struct packed {
        logic                    kind;
        logic [7:0]              data_byte;
        logic                    first_byte;
        logic [1:0]              frame_status;
        logic [LEN_OUT_BITS-1:0] payload_length;
    } result_t;

    // table entry: index shifted into the top byte, eight polynomial steps
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = ((c & CRC_TOP) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // byte-wise crc update
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
        return crc_table(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, data};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/flag_framed_destuffer_crc16_check.sv
// top level of the flag-framed destuffer with crc-16 check
// depends on ffd_pkg and assert_macros.svh
//
//   channel | dir | ports                                   | handshake
//   --------+-----+-----------------------------------------+----------------
//   s_      | in  | s_rx_byte                               | s_valid/s_ready
//   m_      | out | m_kind m_data_byte m_first_byte         | m_valid/m_ready
//           |     | m_frame_status m_payload_length         |
//
// one byte is taken per cycle while s_ready is high; frame state, crc and any
// result are written at the accepting edge, so m_valid is high from the cycle
// after the request; a two-entry output (register plus skid slot) keeps s_ready
// high for one further result while a result waits; s_ready is registered
// synchronous active-low reset returns the block to idle, outside any frame
`default_nettype none
`include "assert_macros.svh"

module flag_framed_destuffer_crc16_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_data_byte,
    output logic             m_first_byte,
    output logic [1:0]       m_frame_status,
    output logic [ffd_pkg::LEN_OUT_BITS-1:0] m_payload_length
);

    localparam logic [ffd_pkg::LENGTH_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ffd_pkg::LENGTH_BITS-1:0] COUNT_ONE =
        {{(ffd_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};

    // frame state
    logic                           frame_open_reg, frame_open_next;
    logic                           esc_reg, esc_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [7:0]                     held0_reg, held0_next;
    logic [7:0]                     held1_reg, held1_next;
    logic [1:0]                     held_count_reg, held_count_next;
    logic [ffd_pkg::LENGTH_BITS-1:0] count_reg, count_next;

    // output register and skid slot
    ffd_pkg::result_t out_reg, out_next;
    ffd_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    logic             accept;
    logic             push;
    logic             pop;
    ffd_pkg::result_t item;
    logic [7:0]       dbyte;
    logic [15:0]      fcs;
    logic [ffd_pkg::LEN_WIDE-1:0] count_wide;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    assign dbyte      = esc_reg ? (s_rx_byte ^ ffd_pkg::ESC_XOR) : s_rx_byte;
    assign fcs        = {held1_reg, held0_reg};
    assign count_wide = ffd_pkg::LEN_WIDE'(count_reg);

    // per-byte framing, destuffing and crc
    always_comb begin
        frame_open_next = frame_open_reg;
        esc_next        = esc_reg;
        crc_next        = crc_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        held_count_next = held_count_reg;
        count_next      = count_reg;
        push            = 1'b0;
        item            = '0;
        if (accept) begin
            if (!frame_open_reg) begin
                // idle: only a flag opens a frame
                if (s_rx_byte == ffd_pkg::FLAG_BYTE) begin
                    frame_open_next = 1'b1;
                    esc_next        = 1'b0;
                    crc_next        = 16'h0000;
                    held_count_next = 2'd0;
                    count_next      = '0;
                end
            end else if (s_rx_byte == ffd_pkg::FLAG_BYTE) begin
                // closing flag: emit status
                push                = 1'b1;
                item.kind           = ffd_pkg::KIND_STATUS;
                item.payload_length = count_wide[ffd_pkg::LEN_OUT_BITS-1:0];
                if (esc_reg) begin
                    item.frame_status = ffd_pkg::STATUS_ESCAPE;
                end else if (held_count_reg < 2'd2) begin
                    item.frame_status = ffd_pkg::STATUS_SHORT;
                end else if (fcs == crc_reg) begin
                    item.frame_status = ffd_pkg::STATUS_GOOD;
                end else begin
                    item.frame_status = ffd_pkg::STATUS_BAD_CRC;
                end
                frame_open_next = 1'b0;
                esc_next        = 1'b0;
            end else if (!esc_reg && s_rx_byte == ffd_pkg::ESC_BYTE) begin
                esc_next = 1'b1;
            end else begin
                esc_next = 1'b0;
                if (held_count_reg < 2'd2) begin
                    // fill the check-sequence hold line
                    if (held_count_reg[0]) begin
                        held1_next = dbyte;
                    end else begin
                        held0_next = dbyte;
                    end
                    held_count_next = held_count_reg + 2'd1;
                end else begin
                    // oldest held byte leaves as payload
                    push            = 1'b1;
                    item.kind       = ffd_pkg::KIND_PAYLOAD;
                    item.data_byte  = held0_reg;
                    item.first_byte = (count_reg == '0);
                    held0_next      = held1_reg;
                    held1_next      = dbyte;
                    crc_next        = ffd_pkg::crc_next(crc_reg, held0_reg);
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_ONE;
                    end
                end
            end
        end
    end

    // output register with skid slot
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next       = item;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_next       = item;
            skid_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            esc_reg        <= 1'b0;
            crc_reg        <= 16'h0000;
            held_count_reg <= 2'd0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            frame_open_reg <= frame_open_next;
            esc_reg        <= esc_next;
            crc_reg        <= crc_next;
            held_count_reg <= held_count_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        out_reg   <= out_next;
        skid_reg  <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_data_byte      = out_reg.data_byte;
    assign m_first_byte     = out_reg.first_byte;
    assign m_frame_status   = out_reg.frame_status;
    assign m_payload_length = out_reg.payload_length;

    // checks
    `ASSERT_CLK(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `ASSERT_NEVER(a_held_count_range, aclk, aresetn, held_count_reg == 2'd3)
    `ASSERT_CLK(a_escape_in_frame, aclk, aresetn, esc_reg |-> frame_open_reg)
    `ASSERT_CLK(a_flag_closes, aclk, aresetn,
        (accept && frame_open_reg && s_rx_byte == ffd_pkg::FLAG_BYTE) |=> !frame_open_reg)

endmodule

`default_nettype wire
